// ----- rtl/core/lxtd_pkg.sv -----
// Package: shared types and constants for the LCG XOR text decrypt core
`default_nettype none
package lxtd_pkg;

  localparam logic [1:0] REG_MULTIPLIER = 2'd0;
  localparam logic [1:0] REG_INCREMENT  = 2'd1;
  localparam logic [1:0] REG_MODULUS    = 2'd2;

  localparam logic [31:0] MULT_RESET = 32'd16811;
  localparam logic [31:0] INC_RESET  = 32'd7;
  localparam logic [31:0] MOD_RESET  = 32'd2147483647;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] PAIR_SCALE   = 8'd10;

  // classified work for the back end
  typedef struct packed {
    logic       has_x;   // a byte is carried (raw for corrupt items)
    logic [7:0] x;
    logic       last;
    logic       corrupt;
  } work_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_MUL, BK_MOD, BK_XOR, BK_OUT
  } bk_state_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/lcg_xor_text_decrypt_core.sv -----
// Top level: LCG XOR text decrypt core with config registers
//
// channel | handshake          | payload
// input   | push / full        | text_char, last_char
// result  | empty / pop        | plain_byte, has_byte, end_of_text, corrupt
// config  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A byte after the seed passes through the back end in order: it is taken from the
// queue, then come 2 multiply steps (16-bit digits), 64 restoring reduction steps,
// 1 XOR step and the result hold. With a zero modulus the reduction is skipped.
// Seed bytes and end-only items skip the multiply and reduction; whitespace and
// pair starts leave the front end only when they carry the end of text.
// Synchronous reset restores register defaults and clears all message state.
// A 2-entry queue lets the front end keep accepting while the back end works;
// an unpopped result stalls the back end, which then fills the queue.
`default_nettype none
module lcg_xor_text_decrypt_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  text_char,
  input  wire logic        last_char,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       plain_byte,
  output logic             has_byte,
  output logic             end_of_text,
  output logic             corrupt,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import lxtd_pkg::*;

  logic [31:0] multiplier, increment, modulus;
  work_t f_data, b_data;
  logic f_push, f_full, b_pop, b_empty, bk_idle;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      multiplier <= MULT_RESET; increment <= INC_RESET; modulus <= MOD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MULTIPLIER: multiplier <= cfg_data;
        REG_INCREMENT:  increment <= cfg_data;
        REG_MODULUS:    modulus <= cfg_data;
        default: ;
      endcase
    end
  end

  lxtd_front u_front (
    .clk, .rst, .push, .full, .text_char, .last_char,
    .wq_data(f_data), .wq_push(f_push), .wq_full(f_full)
  );

  lxtd_fifo #(.Width($bits(work_t)), .Depth(2)) u_fifo (
    .clk, .rst, .push(f_push), .wdata(f_data), .full(f_full),
    .pop(b_pop), .rdata(b_data), .empty(b_empty)
  );

  lxtd_back u_back (
    .clk, .rst, .multiplier, .increment, .modulus,
    .wq_data(b_data), .wq_empty(b_empty), .wq_pop(b_pop),
    .empty, .pop, .plain_byte, .has_byte, .end_of_text, .corrupt,
    .idle(bk_idle)
  );

  assert property (@(posedge clk) disable iff (rst)
    (!b_empty) |-> !bk_idle) else $error("idle with queued work");

endmodule
`default_nettype wire

// ----- rtl/core/lxtd_front.sv -----
// Front end: strips whitespace, decodes letter and pair bytes
`default_nettype none
module lxtd_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  wire logic [7:0]      text_char,
  input  wire logic            last_char,
  output lxtd_pkg::work_t      wq_data,
  output logic                 wq_push,
  input  wire logic            wq_full
);
  import lxtd_pkg::*;

  logic       digit_pending;
  logic [7:0] pending_char;
  logic [7:0] k, e, x_pair;
  logic       take;
  work_t      w;

  assign full = wq_full;
  assign take = push && !wq_full;

  // pair decode
  always_comb begin
    k = pending_char - CHAR_ZERO;
    e = k[0] ? (text_char - CHAR_UPPER_A) : (text_char - CHAR_LOWER_A);
    x_pair = 8'(PAIR_SCALE * e + k);
  end

  // classify one character
  always_comb begin
    w = '0;
    w.last = last_char;
    if (!is_space(text_char)) begin
      if (digit_pending) begin
        w.has_x = 1'b1;
        w.x = x_pair;
      end else if (is_letter(text_char)) begin
        w.has_x = 1'b1;
        w.x = text_char;
      end
    end
    // dangling pair start at end of text
    if (last_char && !w.has_x && (digit_pending ||
        (!is_space(text_char) && !is_letter(text_char)))) begin
      w.has_x = 1'b1;
      w.corrupt = 1'b1;
      w.x = digit_pending ? pending_char : text_char;
    end
  end

  assign wq_data = w;
  assign wq_push = take && (w.has_x || last_char);

  // pair holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_pending <= 1'b0;
      pending_char <= '0;
    end else if (take) begin
      if (last_char) begin
        digit_pending <= 1'b0;
      end else if (!is_space(text_char)) begin
        if (digit_pending) begin
          digit_pending <= 1'b0;
        end else if (!is_letter(text_char)) begin
          digit_pending <= 1'b1;
          pending_char <= text_char;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    wq_push |-> (wq_data.has_x || wq_data.last)) else $error("empty work pushed");
  assert property (@(posedge clk) disable iff (rst)
    wq_data.corrupt |-> wq_data.last) else $error("corrupt without end");
  assert property (@(posedge clk) disable iff (rst)
    (take && last_char) |=> !digit_pending) else $error("pair survives end");

endmodule
`default_nettype wire

// ----- rtl/core/lxtd_fifo.sv -----
// Small register queue between front and back ends
`default_nettype none
module lxtd_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [Width-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [Width-1:0]      rdata,
  output logic                  empty
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem [Depth];
  logic [AW-1:0]    wp, rp;
  logic [AW:0]      cnt;

  assign full  = (cnt == (AW+1)'(Depth));
  assign empty = (cnt == '0);
  assign rdata = mem[rp];

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push && !full) begin
        wp <= (wp == AW'(Depth-1)) ? '0 : wp + 1'b1;
      end
      if (pop && !empty) begin
        rp <= (rp == AW'(Depth-1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wp] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/lxtd_back.sv -----
// Back end: LCG advance with sequential multiply and reduction, XOR, result register
`default_nettype none
module lxtd_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [31:0]     multiplier,
  input  wire logic [31:0]     increment,
  input  wire logic [31:0]     modulus,
  input  lxtd_pkg::work_t      wq_data,
  input  wire logic            wq_empty,
  output logic                 wq_pop,
  output logic                 empty,
  input  wire logic            pop,
  output logic [7:0]           plain_byte,
  output logic                 has_byte,
  output logic                 end_of_text,
  output logic                 corrupt,
  output logic                 idle
);
  import lxtd_pkg::*;

  bk_state_t state, state_next;
  work_t     cur;
  logic [31:0] seed_value;
  logic        seed_taken, stopped_at_nul;
  logic [63:0] prod;       // product accumulator
  logic [1:0]  mstep;      // 16-bit multiplier digit index
  logic [64:0] rem;        // restoring division remainder window
  logic [5:0]  bitn;
  logic [63:0] dividend;
  logic        out_valid;
  logic [47:0] pp;
  logic [64:0] trial;
  logic [7:0]  p;
  logic        deliver;

  assign pp = seed_value * multiplier[mstep[0]*16 +: 16];
  assign p  = cur.x ^ seed_value[7:0];
  assign trial = {rem[63:0], dividend[63]} - {33'd0, modulus};
  assign deliver = cur.has_x && seed_taken && !stopped_at_nul && (p != '0);
  assign empty = !out_valid;
  assign idle = (state == BK_IDLE) && wq_empty;

  // next state
  always_comb begin
    state_next = state;
    wq_pop = 1'b0;
    case (state)
      BK_IDLE: if (!wq_empty) begin
        wq_pop = 1'b1;
        // seed bytes and non-byte items skip the LCG
        state_next = (wq_data.has_x && seed_taken) ? BK_MUL : BK_XOR;
      end
      BK_MUL: if (mstep == 2'd1) state_next = (modulus == '0) ? BK_XOR : BK_MOD;
      BK_MOD: if (bitn == 6'd63) state_next = BK_XOR;
      BK_XOR: state_next = BK_OUT;
      BK_OUT: if (!out_valid) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // datapath and LCG state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      seed_value <= '0; seed_taken <= 1'b0; stopped_at_nul <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop && out_valid) out_valid <= 1'b0;
      case (state)
        BK_IDLE: if (!wq_empty) begin
          cur <= wq_data;
          mstep <= '0;
          prod <= {32'd0, increment};
        end
        BK_MUL: begin
          prod <= prod + (64'(pp) << (mstep[0] ? 16 : 0));
          mstep <= mstep + 1'b1;
          rem <= '0; bitn <= '0;
          dividend <= prod + (64'(pp) << (mstep[0] ? 16 : 0));
          if (mstep == 2'd1 && modulus == '0)
            seed_value <= 32'(prod + (64'(pp) << 16));
        end
        BK_MOD: begin
          if (!trial[64]) rem <= trial;
          else rem <= {rem[63:0], dividend[63]};
          dividend <= {dividend[62:0], 1'b0};
          bitn <= bitn + 1'b1;
          if (bitn == 6'd63)
            seed_value <= !trial[64] ? trial[31:0] : {rem[30:0], dividend[63]};
        end
        BK_XOR: begin
          has_byte <= deliver;
          plain_byte <= deliver ? p : '0;
          end_of_text <= cur.last; corrupt <= cur.corrupt;
          // end of text clears the message state
          if (cur.last) begin
            seed_value <= '0; seed_taken <= 1'b0; stopped_at_nul <= 1'b0;
          end else if (cur.has_x) begin
            if (!seed_taken) begin
              seed_taken <= 1'b1;
              seed_value <= {24'd0, cur.x};
            end else if (!stopped_at_nul && p == '0) begin
              stopped_at_nul <= 1'b1;
            end
          end
          if (cur.last || deliver)
            out_valid <= 1'b1;
        end
        BK_OUT: ;
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == BK_MOD) |-> (modulus != '0)) else $error("reduction by zero");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_byte) |-> end_of_text) else $error("empty non-end result");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && has_byte) |-> (plain_byte != '0)) else $error("zero byte delivered");

endmodule
`default_nettype wire
